// ===== hw/rtl/aapr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the cordic arctangent table
package aapr_pkg;

  localparam int MAG_W        = 32;
  localparam int NRM_MSB      = 30;
  localparam int SH_W         = 5;
  localparam int CS_W         = 34;
  localparam int MW           = 35;
  localparam int CORDIC_STEPS = 30;
  localparam int ISQ_STEPS    = 32;
  localparam int DIV_STEPS    = 31;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;
  localparam int Q_CNT_W      = 3;

  localparam logic signed [CS_W-1:0] CORDIC_X0 = CS_W'(652032874);
  localparam logic signed [CS_W-1:0] ONE_Q30   = CS_W'(2**30);

  typedef struct packed {
    logic empty;
    logic full_soon;
  } aapr_qstat_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/axis_angle_point_rotation.sv =====
`timescale 1ns / 1ps
// axis-angle point rotation, top level
//
// Rotates a signed q16.16 point about an axis of any nonzero length by a
// binary angle (2^ANGLE_WIDTH is one full turn), Rodrigues form.
// Input: an item is taken at a rising edge with start high and busy low.
// Output: out_strobe is high for one cycle with the rotated point and the
// zero_axis and clipped flags; the receiver has no way to hold it off.
// Stages: 1 front register, the queue with its registered read and 71
// back-end stages, of which 32 are the square root of the axis length and
// 31 the unit-axis divide. Throughput: one item per cycle while busy is low.
// The back end never stalls, so the queue stays nearly empty and busy only
// rises if it fills to three entries.
// A zero axis passes the point through with zero_axis set.
// Reset (rst_n low, synchronous) empties the queue and drops every item
// in flight; no result strobes until new items come in.
module axis_angle_point_rotation import aapr_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int AXIS_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_x,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_y,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_z,
  input  logic [ANGLE_WIDTH-1:0]        in_turn_angle,
  output logic                          out_strobe,
  output logic signed [COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [COORD_WIDTH-1:0] out_rotated_z,
  output logic                          out_zero_axis,
  output logic                          out_clipped
);

  localparam int ITEM_W = 3*COORD_WIDTH + 3*MAG_W + 4 + ANGLE_WIDTH;

  logic              item_valid;
  logic [ITEM_W-1:0] item;
  logic              q_valid;
  logic [ITEM_W-1:0] q_data;
  aapr_qstat_t       q_stat;

  assign busy = q_stat.full_soon;

  aapr_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .AXIS_WIDTH  (AXIS_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (q_stat.full_soon),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .in_turn_angle (in_turn_angle),
    .item_valid    (item_valid),
    .item          (item)
  );

  aapr_queue #(
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_valid),
    .push_data (item),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  aapr_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_data   (q_data),
    .out_valid (out_strobe),
    .out_x     (out_rotated_x),
    .out_y     (out_rotated_y),
    .out_z     (out_rotated_z),
    .out_zero  (out_zero_axis),
    .out_clip  (out_clipped)
  );

endmodule

// ===== hw/rtl/aapr_front.sv =====
`timescale 1ns / 1ps
// front end: takes items, flags a zero axis and normalizes axis magnitudes
module aapr_front import aapr_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int AXIS_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int ITEM_W      = 3*32 + 3*32 + 4 + 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_x,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_y,
  input  logic signed [AXIS_WIDTH-1:0]  in_axis_z,
  input  logic [ANGLE_WIDTH-1:0]        in_turn_angle,
  output logic                          item_valid,
  output logic [ITEM_W-1:0]             item
);

  logic [AXIS_WIDTH-1:0] ax [3];
  logic [MAG_W-1:0]      mag [3];
  logic [MAG_W-1:0]      magn [3];
  logic [2:0]            neg;
  logic [MAG_W-1:0]      mx;
  logic [SH_W-1:0]       msb;
  logic [SH_W-1:0]       sh;
  logic                  zero;
  logic                  item_valid_r;
  logic [ITEM_W-1:0]     item_r;

  always_comb begin
    ax[0] = in_axis_x;
    ax[1] = in_axis_y;
    ax[2] = in_axis_z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = ax[i][AXIS_WIDTH-1];
      mag[i] = neg[i] ? MAG_W'(AXIS_WIDTH'(~ax[i] + 1'b1)) : MAG_W'(ax[i]);
    end
    mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mx) begin
      mx = mag[2];
    end
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx[b]) begin
        msb = SH_W'(b);
      end
    end
    // bring the largest magnitude up to bit 30
    sh   = (msb >= SH_W'(NRM_MSB)) ? '0 : SH_W'(NRM_MSB) - msb;
    zero = (mx == '0);
    for (int i = 0; i < 3; i++) begin
      magn[i] = mag[i] << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= {in_turn_angle, zero, neg, magn[2], magn[1], magn[0],
                 in_point_z, in_point_y, in_point_x};
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/aapr_queue.sv =====
`timescale 1ns / 1ps
// short item queue between front end and back end, registered read
module aapr_queue import aapr_pkg::*; #(
  parameter int ITEM_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [ITEM_W-1:0] push_data,
  output logic              pop_valid,
  output logic [ITEM_W-1:0] pop_data,
  output aapr_qstat_t       stat
);

  logic [ITEM_W-1:0]  mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               pop_valid_r;
  logic [ITEM_W-1:0]  pop_data_r;
  logic               pop;

  // the back end never stalls, so anything stored leaves at once
  assign pop = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pop_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      pop_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      pop_data_r <= mem[rd_ptr_r];
    end
  end

  assign pop_valid      = pop_valid_r;
  assign pop_data       = pop_data_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full_soon = (count_r >= Q_CNT_W'(Q_DEPTH - 1));

endmodule

// ===== hw/rtl/aapr_cordic.sv =====
`timescale 1ns / 1ps
// pipelined rotation-mode cordic giving cos and sin in q4.30
module aapr_cordic import aapr_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic [ANGLE_WIDTH-1:0] ang,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic signed [CS_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] z_r [CORDIC_STEPS+1];
  logic                   flip_r [CORDIC_STEPS+1];
  logic signed [CS_W-1:0] x_nxt [CORDIC_STEPS];
  logic signed [CS_W-1:0] y_nxt [CORDIC_STEPS];
  logic signed [CS_W-1:0] z_nxt [CORDIC_STEPS];
  logic [31:0]            a32;
  logic [31:0]            a_adj;
  logic                   pflip;

  always_comb begin
    a32   = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    // second and third quadrant: rotate by half a turn, negate later
    pflip = a32[31] ^ a32[30];
    a_adj = pflip ? {~a32[31], a32[30:0]} : a32;
    for (int j = 0; j < CORDIC_STEPS; j++) begin
      if (!z_r[j][CS_W-1]) begin
        x_nxt[j] = x_r[j] - (y_r[j] >>> j);
        y_nxt[j] = y_r[j] + (x_r[j] >>> j);
        z_nxt[j] = z_r[j] - $signed({{(CS_W-32){1'b0}}, atan_entry(5'(j))});
      end else begin
        x_nxt[j] = x_r[j] + (y_r[j] >>> j);
        y_nxt[j] = y_r[j] - (x_r[j] >>> j);
        z_nxt[j] = z_r[j] + $signed({{(CS_W-32){1'b0}}, atan_entry(5'(j))});
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_X0;
    y_r[0]    <= '0;
    z_r[0]    <= $signed({{(CS_W-32){a_adj[31]}}, a_adj});
    flip_r[0] <= pflip;
    for (int j = 0; j < CORDIC_STEPS; j++) begin
      x_r[j+1]    <= x_nxt[j];
      y_r[j+1]    <= y_nxt[j];
      z_r[j+1]    <= z_nxt[j];
      flip_r[j+1] <= flip_r[j];
    end
  end

  assign cos_o = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign sin_o = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];

endmodule

// ===== hw/rtl/aapr_back.sv =====
`timescale 1ns / 1ps
// back end pipeline: axis length, unit axis, rotation matrix, point transform
module aapr_back import aapr_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16,
  parameter int ITEM_W      = 3*32 + 3*32 + 4 + 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ITEM_W-1:0]             in_data,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_zero,
  output logic                          out_clip
);

  localparam int M_OFF  = 3*COORD_WIDTH;
  localparam int N_OFF  = M_OFF + 3*MAG_W;
  localparam int Z_OFF  = N_OFF + 3;
  localparam int T_N    = 2;
  localparam int T_RT   = T_N + ISQ_STEPS;
  localparam int T_DIV  = T_RT + DIV_STEPS;
  localparam int T_M    = T_DIV + 3;
  localparam int T_SUM  = T_M + 2;
  localparam int LO_W   = COORD_WIDTH / 2;
  localparam int HI_W   = COORD_WIDTH - LO_W;
  localparam int PLO_W  = MW + LO_W + 1;
  localparam int PHI_W  = MW + HI_W;
  localparam int SLO_W  = PLO_W + 2;
  localparam int SHI_W  = PHI_W + 2;
  localparam int TOT_W  = SHI_W + LO_W + 1;
  localparam int RES_W  = TOT_W - 30;

  // item sideband, one copy per stage
  logic [ITEM_W-1:0] side_r [1:T_SUM];
  logic              v_r    [1:T_SUM];

  // squares and their sum
  logic [63:0] sq_r [3];
  logic [63:0] n_r;

  // square root, one result bit per stage
  logic [63:0] sn_in [ISQ_STEPS];
  logic [63:0] sres_in [ISQ_STEPS];
  logic [63:0] sn_r [ISQ_STEPS];
  logic [63:0] sres_r [ISQ_STEPS];
  logic [63:0] sn_nxt [ISQ_STEPS];
  logic [63:0] sres_nxt [ISQ_STEPS];
  logic [63:0] trial;
  logic [31:0] root;

  // three dividers sharing the divisor, one quotient bit per stage
  logic [63:0]          drem_in [3][DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_in [3][DIV_STEPS];
  logic [31:0]          dd_in [DIV_STEPS];
  logic [63:0]          drem_r [3][DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_r [3][DIV_STEPS];
  logic [31:0]          dd_r [DIV_STEPS];
  logic [63:0]          drem_nxt [3][DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_nxt [3][DIV_STEPS];
  logic [63:0]          dsub;

  logic signed [CS_W-1:0] cs_c, cs_s;

  // matrix build
  logic signed [31:0]     u [3];
  logic signed [63:0]     uu_r [6];
  logic signed [65:0]     us_r [3];
  logic signed [CS_W-1:0] c_pr_r, t_pr_r, c_ut_r;
  logic signed [63:0]     uuh [6];
  logic signed [65:0]     ush [3];
  logic signed [67:0]     ut_r [6];
  logic signed [CS_W-1:0] sr_r [3];
  logic signed [67:0]     uth [6];
  logic signed [MW-1:0]   ur [6];
  logic signed [MW-1:0]   m_nxt [9];
  logic signed [MW-1:0]   m_r [9];

  // point transform
  logic signed [COORD_WIDTH-1:0] pm [3];
  logic signed [COORD_WIDTH-1:0] ps [3];
  logic signed [PLO_W-1:0]       plo_r [9];
  logic signed [PHI_W-1:0]       phi_r [9];
  logic signed [SLO_W-1:0]       slo_r [3];
  logic signed [SHI_W-1:0]       shi_r [3];
  logic signed [TOT_W-1:0]       tot [3];
  logic signed [RES_W-1:0]       res [3];
  logic signed [COORD_WIDTH-1:0] sat [3];
  logic [2:0]                    clip;

  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic                          out_zero_r, out_clip_r;

  assign root = sres_r[ISQ_STEPS-1][31:0];

  always_comb begin
    sn_in[0]   = n_r;
    sres_in[0] = '0;
    for (int j = 1; j < ISQ_STEPS; j++) begin
      sn_in[j]   = sn_r[j-1];
      sres_in[j] = sres_r[j-1];
    end
    trial = '0;
    for (int j = 0; j < ISQ_STEPS; j++) begin
      trial = sres_in[j] + (64'd1 << (62 - 2*j));
      if (sn_in[j] >= trial) begin
        sn_nxt[j]   = sn_in[j] - trial;
        sres_nxt[j] = (sres_in[j] >> 1) + (64'd1 << (62 - 2*j));
      end else begin
        sn_nxt[j]   = sn_in[j];
        sres_nxt[j] = sres_in[j] >> 1;
      end
    end
  end

  always_comb begin
    dd_in[0] = root;
    for (int j = 1; j < DIV_STEPS; j++) begin
      dd_in[j] = dd_r[j-1];
    end
    dsub = '0;
    for (int i = 0; i < 3; i++) begin
      // rounded quotient: add half the divisor up front
      drem_in[i][0] = (64'(side_r[T_RT][M_OFF + i*MAG_W +: MAG_W]) << 30)
                      + 64'(root >> 1);
      dq_in[i][0]   = '0;
      for (int j = 1; j < DIV_STEPS; j++) begin
        drem_in[i][j] = drem_r[i][j-1];
        dq_in[i][j]   = dq_r[i][j-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        dsub = 64'(dd_in[j]) << (DIV_STEPS - 1 - j);
        if (drem_in[i][j] >= dsub) begin
          drem_nxt[i][j] = drem_in[i][j] - dsub;
          dq_nxt[i][j]   = {dq_in[i][j][DIV_STEPS-2:0], 1'b1};
        end else begin
          drem_nxt[i][j] = drem_in[i][j];
          dq_nxt[i][j]   = {dq_in[i][j][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  aapr_cordic #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_cordic (
    .clk   (clk),
    .ang   (side_r[T_RT][Z_OFF + 1 +: ANGLE_WIDTH]),
    .cos_o (cs_c),
    .sin_o (cs_s)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = side_r[T_DIV][N_OFF + i] ? -$signed({1'b0, dq_r[i][DIV_STEPS-1]})
                                      :  $signed({1'b0, dq_r[i][DIV_STEPS-1]});
      ush[i] = us_r[i] + (66'sd1 <<< 29);
    end
    for (int k = 0; k < 6; k++) begin
      uuh[k] = uu_r[k] + (64'sd1 <<< 29);
      uth[k] = ut_r[k] + (68'sd1 <<< 29);
      ur[k]  = $signed(uth[k][64:30]);
    end
    // rows of c*I + s*[u]x + (1-c)*u*u^T
    m_nxt[0] = ur[0] + MW'(c_ut_r);
    m_nxt[1] = ur[3] - MW'(sr_r[2]);
    m_nxt[2] = ur[4] + MW'(sr_r[1]);
    m_nxt[3] = ur[3] + MW'(sr_r[2]);
    m_nxt[4] = ur[1] + MW'(c_ut_r);
    m_nxt[5] = ur[5] - MW'(sr_r[0]);
    m_nxt[6] = ur[4] - MW'(sr_r[1]);
    m_nxt[7] = ur[5] + MW'(sr_r[0]);
    m_nxt[8] = ur[2] + MW'(c_ut_r);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pm[j] = $signed(side_r[T_M][j*COORD_WIDTH +: COORD_WIDTH]);
      ps[j] = $signed(side_r[T_SUM][j*COORD_WIDTH +: COORD_WIDTH]);
    end
    for (int i = 0; i < 3; i++) begin
      tot[i] = (TOT_W'(shi_r[i]) <<< LO_W) + TOT_W'(slo_r[i])
               + $signed(TOT_W'(1) << 29);
      res[i] = $signed(tot[i][TOT_W-1:30]);
      clip[i] = 1'b0;
      sat[i]  = res[i][COORD_WIDTH-1:0];
      if (res[i] > $signed({{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}})) begin
        sat[i]  = $signed({1'b0, {(COORD_WIDTH-1){1'b1}}});
        clip[i] = 1'b1;
      end
      if (res[i] < $signed({{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}})) begin
        sat[i]  = $signed({1'b1, {(COORD_WIDTH-1){1'b0}}});
        clip[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= T_SUM; k++) begin
        v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= T_SUM; k++) begin
        v_r[k] <= v_r[k-1];
      end
      out_valid_r <= v_r[T_SUM];
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= in_data;
    for (int k = 2; k <= T_SUM; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= in_data[M_OFF + i*MAG_W +: MAG_W] * in_data[M_OFF + i*MAG_W +: MAG_W];
    end
    n_r <= sq_r[0] + sq_r[1] + sq_r[2];
    for (int j = 0; j < ISQ_STEPS; j++) begin
      sn_r[j]   <= sn_nxt[j];
      sres_r[j] <= sres_nxt[j];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      dd_r[j] <= dd_in[j];
      for (int i = 0; i < 3; i++) begin
        drem_r[i][j] <= drem_nxt[i][j];
        dq_r[i][j]   <= dq_nxt[i][j];
      end
    end
    uu_r[0] <= u[0] * u[0];
    uu_r[1] <= u[1] * u[1];
    uu_r[2] <= u[2] * u[2];
    uu_r[3] <= u[0] * u[1];
    uu_r[4] <= u[0] * u[2];
    uu_r[5] <= u[1] * u[2];
    for (int i = 0; i < 3; i++) begin
      us_r[i] <= u[i] * cs_s;
      sr_r[i] <= $signed(ush[i][63:30]);
    end
    c_pr_r <= cs_c;
    t_pr_r <= ONE_Q30 - cs_c;
    for (int k = 0; k < 6; k++) begin
      ut_r[k] <= $signed(uuh[k][63:30]) * t_pr_r;
    end
    c_ut_r <= c_pr_r;
    for (int k = 0; k < 9; k++) begin
      m_r[k] <= m_nxt[k];
    end
    // split each coordinate into halves to keep the multipliers narrow
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[i*3+j] <= m_r[i*3+j] * $signed({1'b0, pm[j][LO_W-1:0]});
        phi_r[i*3+j] <= m_r[i*3+j] * $signed(pm[j][COORD_WIDTH-1:LO_W]);
      end
      slo_r[i] <= SLO_W'(plo_r[i*3]) + SLO_W'(plo_r[i*3+1]) + SLO_W'(plo_r[i*3+2]);
      shi_r[i] <= SHI_W'(phi_r[i*3]) + SHI_W'(phi_r[i*3+1]) + SHI_W'(phi_r[i*3+2]);
    end
    if (side_r[T_SUM][Z_OFF]) begin
      out_x_r    <= ps[0];
      out_y_r    <= ps[1];
      out_z_r    <= ps[2];
      out_zero_r <= 1'b1;
      out_clip_r <= 1'b0;
    end else begin
      out_x_r    <= sat[0];
      out_y_r    <= sat[1];
      out_z_r    <= sat[2];
      out_zero_r <= 1'b0;
      out_clip_r <= |clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_zero  = out_zero_r;
  assign out_clip  = out_clip_r;

endmodule

// ===== tb/tb_axis_angle_point_rotation.sv =====
`timescale 1ns / 1ps
// testbench for the axis-angle point rotation block
module tb_axis_angle_point_rotation import aapr_pkg::*;;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ax, ay, az;
    logic [15:0]        ang;
  } point_item_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               zero_axis;
    logic               clipped;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [15:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [15:0] in_turn_angle = '0;
  logic out_strobe;
  logic signed [31:0] out_rotated_x, out_rotated_y, out_rotated_z;
  logic out_zero_axis, out_clipped;

  rotated_t pending_rotations[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int zero_seen = 0;
  int clip_seen = 0;
  int idle_pct = 0;

  axis_angle_point_rotation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_turn_angle(in_turn_angle),
    .out_strobe(out_strobe), .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y), .out_rotated_z(out_rotated_z),
    .out_zero_axis(out_zero_axis), .out_clipped(out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint rnd30(input longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void cordic_cos_sin(input logic [15:0] ang, output longint c,
                                         output longint s);
    logic [31:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0000};
    // second and third quadrant: rotate by half a turn, negate afterwards
    flip = a[31] ^ a[30];
    if (flip) a = a + 32'h80000000;
    z = $signed(a);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_entry(i[4:0]));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_entry(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic rotated_t predict_rotation(input point_item_t it);
    rotated_t res;
    longint unsigned mag[3], mx, n, r;
    longint axv[3], u[3], m[3][3], p[3], c, s, t;
    longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
    logic signed [95:0] acc;
    logic signed [31:0] out3[3];
    axv[0] = it.ax; axv[1] = it.ay; axv[2] = it.az;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (axv[i] < 0) ? -axv[i] : axv[i];
      if (mag[i] > mx) mx = mag[i];
    end
    res.zero_axis = 1'b0;
    res.clipped = 1'b0;
    if (mx == 0) begin
      res.rx = it.px; res.ry = it.py; res.rz = it.pz;
      res.zero_axis = 1'b1;
      return res;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    n = 0;
    for (int i = 0; i < 3; i++) n = n + mag[i] * mag[i];
    r = int_sqrt(n);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(((mag[i] << 30) + (r >> 1)) / r);
      if (axv[i] < 0) u[i] = -u[i];
    end
    cordic_cos_sin(it.ang, c, s);
    t = (64'sd1 <<< 30) - c;
    xx = rnd30(rnd30(u[0] * u[0]) * t);
    yy = rnd30(rnd30(u[1] * u[1]) * t);
    zz = rnd30(rnd30(u[2] * u[2]) * t);
    xy = rnd30(rnd30(u[0] * u[1]) * t);
    xz = rnd30(rnd30(u[0] * u[2]) * t);
    yz = rnd30(rnd30(u[1] * u[2]) * t);
    sx = rnd30(u[0] * s); sy = rnd30(u[1] * s); sz = rnd30(u[2] * s);
    m[0][0] = xx + c;  m[0][1] = xy - sz; m[0][2] = xz + sy;
    m[1][0] = xy + sz; m[1][1] = yy + c;  m[1][2] = yz - sx;
    m[2][0] = xz - sy; m[2][1] = yz + sx; m[2][2] = zz + c;
    for (int i = 0; i < 3; i++) begin
      acc = 96'(m[i][0]) * 96'(p[0]) + 96'(m[i][1]) * 96'(p[1])
          + 96'(m[i][2]) * 96'(p[2]);
      acc = (acc + 96'sd536870912) >>> 30;
      if (acc > 96'sd2147483647) begin
        acc = 96'sd2147483647; res.clipped = 1'b1;
      end
      if (acc < -96'sd2147483648) begin
        acc = -96'sd2147483648; res.clipped = 1'b1;
      end
      out3[i] = acc[31:0];
    end
    res.rx = out3[0]; res.ry = out3[1]; res.rz = out3[2];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // busy and the strobe only change at rising edges, so the falling edge is a clean sample
  always @(negedge clk) begin
    rotated_t w;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_rotations.size() == 0) begin
        report_mismatch("strobe with no item outstanding", 32'd1, 32'd0);
      end else begin
        w = pending_rotations.pop_front();
        if (out_rotated_x !== w.rx) report_mismatch("rotated_x", out_rotated_x, w.rx);
        if (out_rotated_y !== w.ry) report_mismatch("rotated_y", out_rotated_y, w.ry);
        if (out_rotated_z !== w.rz) report_mismatch("rotated_z", out_rotated_z, w.rz);
        if (out_zero_axis !== w.zero_axis)
          report_mismatch("zero_axis", out_zero_axis, w.zero_axis);
        if (out_clipped !== w.clipped) report_mismatch("clipped", out_clipped, w.clipped);
        if (w.zero_axis) zero_seen++;
        if (w.clipped) clip_seen++;
      end
    end
  end

  // called right after a rising edge; leaves start high after acceptance
  task automatic send_item(input point_item_t it);
    logic ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= it.px; in_point_y <= it.py; in_point_z <= it.pz;
    in_axis_x <= it.ax; in_axis_y <= it.ay; in_axis_z <= it.az;
    in_turn_angle <= it.ang;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    pending_rotations.push_back(predict_rotation(it));
    items_sent++;
  endtask

  function automatic point_item_t make_item(input logic signed [31:0] px, py, pz,
                                            input logic signed [15:0] ax, ay, az,
                                            input logic [15:0] ang);
    point_item_t it;
    it.px = px; it.py = py; it.pz = pz;
    it.ax = ax; it.ay = ay; it.az = az; it.ang = ang;
    return it;
  endfunction

  function automatic point_item_t random_item();
    point_item_t it;
    int k;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    k = $urandom_range(9);
    // mostly modest points so clipping stays occasional
    if (k < 6) begin
      it.px = it.px >>> $urandom_range(31, 2);
      it.py = it.py >>> $urandom_range(31, 2);
      it.pz = it.pz >>> $urandom_range(31, 2);
    end
    it.ax = 16'($urandom); it.ay = 16'($urandom); it.az = 16'($urandom);
    k = $urandom_range(19);
    if (k == 0) begin
      it.ax = '0; it.ay = '0; it.az = '0;
    end else if (k < 4) begin
      it.ax = it.ax >>> $urandom_range(15);
      it.ay = (k == 1) ? '0 : it.ay >>> $urandom_range(15);
      it.az = (k == 2) ? '0 : it.az >>> $urandom_range(15);
    end
    it.ang = 16'($urandom);
    return it;
  endfunction

  task automatic test_directed();
    logic [15:0] angs[6] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd8192};
    idle_pct = 0;
    send_item(make_item(32'sd65536, 32'sd131072, -32'sd65536, 16'sd0, 16'sd0, 16'sd0, 16'd1234));
    send_item(make_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd0, 16'sd0, 16'sd0,
                        16'hffff));
    foreach (angs[i])
      send_item(make_item(32'sd65536, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd1, angs[i]));
    send_item(make_item(32'sd65536, 32'sd65536, 32'sd65536, -16'sd32768, -16'sd32768,
                        -16'sd32768, 16'd21845));
    send_item(make_item(-32'sd200000, 32'sd7, 32'sd300000, 16'sd32767, 16'sd1, -16'sd32768,
                        16'd40000));
    send_item(make_item(32'sd1, -32'sd1, 32'sd0, 16'sd1, 16'sd1, 16'sd1, 16'd65535));
    // full-scale points rotated by an eighth turn overflow
    send_item(make_item(32'h7fffffff, 32'h7fffffff, 32'h0, 16'sd0, 16'sd0, 16'sd100, 16'd8192));
    send_item(make_item(32'h80000000, 32'h80000000, 32'h80000000, 16'sd3, -16'sd5, 16'sd7,
                        16'd12000));
    send_item(make_item(32'h80000000, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd1, 16'd32768));
    send_item(make_item(32'h7fffffff, 32'h1, 32'hffffffff, 16'sd0, -16'sd1, 16'sd0, 16'd16384));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_item(random_item());
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_pause_drain();
    idle_pct = 0;
    repeat (10) send_item(random_item());
    start <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (10) send_item(random_item());
    start <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100, 0);
    test_random(100, 74);
    test_pause_drain();
    test_random(80, 0);
    test_random(100, 30);
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
    $display("%0d items sent, %0d results checked", items_sent, results_seen);
    $display("%0d zero-axis pass-throughs and %0d saturated results among them",
             zero_seen, clip_seen);
    if (errors == 0 && pending_rotations.size() == 0) begin
      $display("axis_angle_point_rotation: match");
    end else begin
      $display("axis_angle_point_rotation: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d items outstanding", pending_rotations.size());
    $display("axis_angle_point_rotation: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/aapr_pkg.sv
hw/rtl/aapr_front.sv
hw/rtl/aapr_queue.sv
hw/rtl/aapr_cordic.sv
hw/rtl/aapr_back.sv
hw/rtl/axis_angle_point_rotation.sv
tb/tb_axis_angle_point_rotation.sv
